>>> rtl/dbf_pkg.sv
// shared types and coefficient tables for the dual band fir filter
package dbf_pkg;

   localparam int TABLE_TAPS     = 21;
   localparam int TABLE_IDX_BITS = $clog2(TABLE_TAPS);

   // band select codes
   localparam int BAND_BREATH = 0;
   localparam int BAND_HEART  = 1;

   // Q1.15 tap values, rounded to nearest
   localparam logic signed [15:0] BREATH_COEF [0:TABLE_TAPS-1] = '{
        16'sd106,  16'sd176,  16'sd351,  16'sd660, 16'sd1103, 16'sd1652, 16'sd2253,
       16'sd2835, 16'sd3321, 16'sd3643, 16'sd3756, 16'sd3643, 16'sd3321, 16'sd2835,
       16'sd2253, 16'sd1652, 16'sd1103,  16'sd660,  16'sd351,  16'sd176,  16'sd106
   };

   localparam logic signed [15:0] HEART_COEF [0:TABLE_TAPS-1] = '{
         16'sd58,   -16'sd32,  -16'sd333, -16'sd1008, -16'sd1911, -16'sd2450, -16'sd1862,
        16'sd206,  16'sd3243,  16'sd5979,  16'sd7080,  16'sd5979,  16'sd3243,   16'sd206,
      -16'sd1862, -16'sd2450, -16'sd1911, -16'sd1008,  -16'sd333,   -16'sd32,    16'sd58
   };

   // delay line control from the handshake logic
   typedef struct packed {
      logic load;
      logic clear;
   } line_ctrl_type;

endpackage

>>> rtl/dbf_delay_line.sv
// shared sample delay line, doubles as the input register of the filter
module dbf_delay_line #(
   parameter int TAPS        = 21,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dbf_pkg::line_ctrl_type        ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   output logic signed [SAMPLE_BITS-1:0] taps [TAPS]
);
   import dbf_pkg::*;

   logic signed [SAMPLE_BITS-1:0] tap_ff [TAPS];
   logic signed [SAMPLE_BITS-1:0] tap_in [TAPS];

   // block start drops the old history before the new sample goes in
   always_comb begin
      tap_in[0] = sample;
      for (int k = 1; k < TAPS; k++) begin
         tap_in[k] = ctrl.clear ? '0 : tap_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            tap_ff[k] <= '0;
         end
      end else if (ctrl.load) begin
         tap_ff <= tap_in;
      end
   end

   assign taps = tap_ff;

endmodule

>>> rtl/dbf_band_sum.sv
// one band: constant-coefficient multiply, sum, round and saturate
module dbf_band_sum #(
   parameter int TAPS        = 21,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16,
   parameter int BAND        = 0
) (
   input  logic signed [SAMPLE_BITS-1:0] taps [TAPS],
   output logic signed [SAMPLE_BITS-1:0] band_out
);
   import dbf_pkg::*;

   localparam int ACC_BITS   = SAMPLE_BITS + COEF_BITS + $clog2(TAPS);
   localparam int UP_SHIFT   = (COEF_BITS >= 16) ? COEF_BITS - 16 : 0;
   localparam int DOWN_SHIFT = (COEF_BITS < 16) ? 16 - COEF_BITS : 0;
   localparam int ROUND_ADD  = (DOWN_SHIFT > 0) ? (1 << (DOWN_SHIFT - 1)) : 0;

   localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (COEF_BITS - 2);
   localparam logic signed [ACC_BITS-1:0] SAT_MAX =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_MIN =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   // Q1.15 tap rescaled to Q1.(COEF_BITS-1), zero past the table
   function automatic logic signed [COEF_BITS-1:0] coef_at(int k);
      int c;
      c = 0;
      if (k < TABLE_TAPS) begin
         c = (BAND == BAND_HEART) ? int'(HEART_COEF[k[TABLE_IDX_BITS-1:0]])
                                  : int'(BREATH_COEF[k[TABLE_IDX_BITS-1:0]]);
      end
      c = ((c <<< UP_SHIFT) + ROUND_ADD) >>> DOWN_SHIFT;
      return COEF_BITS'(c);
   endfunction

   logic signed [ACC_BITS-1:0] prod [TAPS];
   logic signed [ACC_BITS-1:0] acc;
   logic signed [ACC_BITS-1:0] rounded;

   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      localparam logic signed [COEF_BITS-1:0] COEF = coef_at(k);
      logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_full;
      assign prod_full = taps[k] * COEF;
      assign prod[k]   = ACC_BITS'(prod_full);
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
         acc = acc + prod[k];
      end
      rounded = (acc + ROUND_HALF) >>> (COEF_BITS - 1);
   end

   always_comb begin
      priority if (rounded > SAT_MAX) begin
         band_out = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rounded < SAT_MIN) begin
         band_out = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         band_out = rounded[SAMPLE_BITS-1:0];
      end
   end

endmodule

>>> rtl/dual_band_fir_filter.sv
// path: an accepted sample is registered in the delay line, then both band sums into the result register
// throughput: one sample per cycle unless the output stalls; both bands are summed in parallel from the tap register
// the input side stalls only while a computed sample waits behind a held result
// reset (synchronous, active high) clears the delay line and both valid flags
// coefficients are fixed constants, so no memory needs clearing
module dual_band_fir_filter #(
   parameter int TAPS        = 21,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_phase_sample,
   input  logic                          req_block_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_breathing_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_heart_out
);
   import dbf_pkg::*;

   logic                          tap_valid_ff;
   logic                          tap_valid_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] breathing_ff;
   logic signed [SAMPLE_BITS-1:0] heart_ff;
   logic signed [SAMPLE_BITS-1:0] breathing_sum;
   logic signed [SAMPLE_BITS-1:0] heart_sum;
   logic signed [SAMPLE_BITS-1:0] taps [TAPS];
   logic                          advance;
   logic                          accept;
   line_ctrl_type                 line_ctrl;

   // result register free or being emptied this cycle
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !tap_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign line_ctrl.load  = accept;
   assign line_ctrl.clear = req_block_start;

   dbf_delay_line #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_delay_line (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (line_ctrl),
      .sample (req_phase_sample),
      .taps   (taps)
   );

   dbf_band_sum #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .BAND        (BAND_BREATH)
   ) u_breath_sum (
      .taps     (taps),
      .band_out (breathing_sum)
   );

   dbf_band_sum #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .BAND        (BAND_HEART)
   ) u_heart_sum (
      .taps     (taps),
      .band_out (heart_sum)
   );

   always_comb begin
      tap_valid_in = tap_valid_ff;
      if (accept) begin
         tap_valid_in = 1'b1;
      end else if (advance) begin
         tap_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? tap_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tap_valid_ff <= tap_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tap_valid_ff) begin
         breathing_ff <= breathing_sum;
         heart_ff     <= heart_sum;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_breathing_out = breathing_ff;
   assign rsp_heart_out     = heart_ff;

endmodule

>>> rtl/dbf_checker.sv
// port-level checks for the dual band fir filter, bound to the top level
module dbf_checker #(
   parameter int SAMPLE_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [SAMPLE_BITS-1:0] req_phase_sample,
   input logic                   req_block_start,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SAMPLE_BITS-1:0] rsp_breathing_out,
   input logic [SAMPLE_BITS-1:0] rsp_heart_out
);

   // a result waiting on the output stays offered
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transaction completed");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_breathing_out) && $stable(rsp_heart_out))
      else $error("stalled result changed");

   // after every accepted sample the output offers a result, its own or an older one still held
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("accepted sample gave no result");

   // with nothing held at the output the input side must be open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind dual_band_fir_filter dbf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dbf_checker (.*);

>>> sim/dual_band_fir_filter_tb.sv
// testbench for the dual band fir filter: queued stimulus, bursty sender, stalling receiver
`timescale 1ns / 100ps

module dual_band_fir_filter_tb;
   import dbf_pkg::*;

   localparam int LINE_DEPTH  = TABLE_TAPS - 1;
   localparam int RANDOM_ITEMS = 1600;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   typedef struct {
      logic signed [15:0] phase;
      logic               start;
   } sample_item_type;

   typedef struct {
      logic signed [15:0] breathing;
      logic signed [15:0] heart;
   } band_pair_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic signed [15:0]  req_phase_sample = '0;
   logic                req_block_start = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [15:0]  rsp_breathing_out;
   logic signed [15:0]  rsp_heart_out;

   sample_item_type     sample_queue[$];
   band_pair_type       band_queue[$];
   logic signed [15:0]  delay_line[0:LINE_DEPTH-1];

   logic                req_taken = 1'b0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  stall_left = 0;
   int                  cycle_count = 0;
   int                  idle_cycles = 0;
   int                  mismatch_count = 0;
   int                  result_count = 0;

   dual_band_fir_filter u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_phase_sample  (req_phase_sample),
      .req_block_start   (req_block_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_breathing_out (rsp_breathing_out),
      .rsp_heart_out     (rsp_heart_out)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // round half up out of q15 and clamp to the sample range
   function automatic logic signed [15:0] round_saturate(longint acc);
      longint r;
      r = (acc + (longint'(1) <<< 14)) >>> 15;
      if (r > longint'(SAMPLE_MAX))
         r = longint'(SAMPLE_MAX);
      if (r < longint'(SAMPLE_MIN))
         r = longint'(SAMPLE_MIN);
      return r[15:0];
   endfunction

   // clear the shared delay line on a block start, sum both bands over it, then shift the new sample in
   function automatic band_pair_type filter_sample(logic signed [15:0] phase, logic start);
      longint        acc_b;
      longint        acc_h;
      band_pair_type r;
      if (start) begin
         for (int i = 0; i < LINE_DEPTH; i++)
            delay_line[i] = '0;
      end
      acc_b = longint'(BREATH_COEF[0]) * longint'(phase);
      acc_h = longint'(HEART_COEF[0]) * longint'(phase);
      for (int k = 1; k < TABLE_TAPS; k++) begin
         acc_b += longint'(BREATH_COEF[k]) * longint'(delay_line[k-1]);
         acc_h += longint'(HEART_COEF[k]) * longint'(delay_line[k-1]);
      end
      for (int k = LINE_DEPTH - 1; k > 0; k--)
         delay_line[k] = delay_line[k-1];
      delay_line[0] = phase;
      r.breathing = round_saturate(acc_b);
      r.heart     = round_saturate(acc_h);
      return r;
   endfunction

   function automatic void add_sample(logic signed [15:0] phase, logic start);
      sample_item_type s;
      s.phase = phase;
      s.start = start;
      sample_queue.push_back(s);
   endfunction

   // sender: bursts of random length with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            sample_item_type s;
            s = sample_queue.pop_front();
            req_phase_sample <= s.phase;
            req_block_start  <= s.start;
            req_valid        <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: steps through four stall patterns in turn, keyed on the cycle counter
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 256) % 4)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (cycle_count % 4 == 0);
         end
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
               if ($urandom_range(0, 3) == 0)
                  stall_left <= $urandom_range(1, 12);
            end
         end
      endcase
   end

   // monitor: predict on each input transaction, check each result transaction
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready)
            band_queue.push_back(filter_sample(req_phase_sample, req_block_start));
         if (rsp_valid && rsp_ready) begin
            band_pair_type want;
            result_count <= result_count + 1;
            if (band_queue.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result transaction %0d: breathing %0d heart %0d",
                           result_count, rsp_breathing_out, rsp_heart_out);
            end else begin
               want = band_queue.pop_front();
               if (want.breathing !== rsp_breathing_out || want.heart !== rsp_heart_out) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= MAX_REPORTS)
                     $display({"mismatch on result %0d: breathing exp %0d got %0d,",
                               " heart exp %0d got %0d"},
                              result_count, want.breathing, rsp_breathing_out,
                              want.heart, rsp_heart_out);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction while work is outstanding
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else if (!reset && (sample_queue.size() != 0 || req_valid || band_queue.size() != 0))
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int kind;
      int len;
      logic signed [15:0] level;
      logic flip;

      for (int i = 0; i < LINE_DEPTH; i++)
         delay_line[i] = '0;

      // directed: extremes, a mid-stream block start, then a full line of maximum
      add_sample(SAMPLE_MIN, 1'b1);
      add_sample(SAMPLE_MAX, 1'b0);
      add_sample(16'sd0, 1'b0);
      add_sample(-16'sd1, 1'b0);
      add_sample(SAMPLE_MAX, 1'b1);
      for (int i = 0; i < LINE_DEPTH; i++)
         add_sample(SAMPLE_MAX, 1'b0);

      while (sample_queue.size() < RANDOM_ITEMS + 25) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            // fresh block with random content
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++)
               add_sample(16'($urandom_range(0, 65535)), (i == 0));
         end else if (kind < 6) begin
            // constant extreme run drives the breathing band into saturation
            level = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            len = $urandom_range(TABLE_TAPS, TABLE_TAPS + 10);
            for (int i = 0; i < len; i++)
               add_sample(level, (i == 0) && $urandom_range(0, 1));
         end else if (kind < 7) begin
            // samples follow the heart tap signs so the heart band saturates
            flip = 1'($urandom_range(0, 1));
            for (int j = 0; j < TABLE_TAPS; j++)
               add_sample(((HEART_COEF[j] > 0) ^ flip) ? SAMPLE_MAX : SAMPLE_MIN,
                          (j == 0) && $urandom_range(0, 1));
         end else if (kind < 9) begin
            // small values with the odd block start
            len = $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
               add_sample($signed(16'($urandom_range(0, 511)) - 16'sd256),
                          ($urandom_range(0, 19) == 0));
         end else begin
            // noise over the full range
            len = $urandom_range(5, 40);
            for (int i = 0; i < len; i++)
               add_sample(16'($urandom_range(0, 65535)), ($urandom_range(0, 9) == 0));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (sample_queue.size() != 0 || req_valid)
         @(negedge clock);
      while (band_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && band_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/dbf_pkg.sv
rtl/dbf_delay_line.sv
rtl/dbf_band_sum.sv
rtl/dual_band_fir_filter.sv
rtl/dbf_checker.sv
sim/dual_band_fir_filter_tb.sv
